>>> hw/rtl/apc_pkg.sv
package apc_pkg;

  // Field widths of the command and result transactions.
  localparam int unsigned FuncW   = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned LoopW   = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned FpsW    = 8;

  // Width of the divider step counter (holds the largest step count).
  localparam int unsigned DivCntW = 6;

  // Register reset values.
  localparam logic [FpsW-1:0]  FpsReset   = 8'd24;
  localparam logic [TimeW-1:0] BlendReset = 32'd32768;

  // Command codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_GOTO   = 3'd2,
    FUNC_PAUSE  = 3'd3,
    FUNC_RESUME = 3'd4,
    FUNC_STOP   = 3'd5
  } func_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_FPS   = 1'b0,
    REG_BLEND = 1'b1
  } reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic div_commit;
    logic post;
    logic mul;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic need_div;
    logic blending;
    logic out_free;
  } ctl_status_t;

endpackage

>>> hw/rtl/apc_cmd_if.sv
interface apc_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [apc_pkg::FuncW-1:0]        func;
  logic [apc_pkg::TimeW-1:0]        delta_time;
  logic [apc_pkg::FrameW-1:0]       move_frames;
  logic                             move_loops;
  logic [apc_pkg::FrameW-1:0]       target_frame;

  modport source (
    output valid, func, delta_time, move_frames, move_loops, target_frame,
    input  ready
  );

  modport sink (
    input  valid, func, delta_time, move_frames, move_loops, target_frame,
    output ready
  );
endinterface

>>> hw/rtl/apc_res_if.sv
interface apc_res_if;
  logic                             valid;
  logic                             ready;
  logic [apc_pkg::FrameW-1:0]       current_frame;
  logic                             is_playing;
  logic [apc_pkg::LoopW-1:0]        loops_done;
  logic                             blend_active;
  logic [apc_pkg::WeightW-1:0]      blend_weight;
  logic [apc_pkg::TimeW-1:0]        play_time;

  modport source (
    output valid, current_frame, is_playing, loops_done, blend_active, blend_weight,
           play_time,
    input  ready
  );

  modport sink (
    input  valid, current_frame, is_playing, loops_done, blend_active, blend_weight,
           play_time,
    output ready
  );
endinterface

>>> hw/rtl/apc_div.sv
module apc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [apc_pkg::TimeW-1:0]    rem_init_i,
  input  logic [apc_pkg::TimeW-1:0]    dividend_i,
  input  logic [apc_pkg::TimeW-1:0]    divisor_i,
  input  logic [apc_pkg::DivCntW-1:0]  steps_i,
  output logic                         done_o,
  output logic [apc_pkg::TimeW-1:0]    quo_o,
  output logic [apc_pkg::TimeW-1:0]    rem_o
);

  logic [apc_pkg::TimeW-1:0]   rem_q, dvd_q, quo_q, dsr_q;
  logic [apc_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;

  logic [apc_pkg::TimeW:0]     trial;
  logic [apc_pkg::TimeW:0]     diff;
  logic                        ge;

  // One restoring step: bring down the next dividend bit and try the subtract.
  // The partial remainder always stays below the divisor.
  assign trial = {rem_q, dvd_q[apc_pkg::TimeW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  // Control: step counter, busy and a one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == apc_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[apc_pkg::TimeW-1:0] : trial[apc_pkg::TimeW-1:0];
      dvd_q <= {dvd_q[apc_pkg::TimeW-2:0], 1'b0};
      quo_q <= {quo_q[apc_pkg::TimeW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  // A new division must not start while one is still running.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  // The last step is followed by the done pulse.
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == apc_pkg::DivCntW'(1)) |=> done_q)
    else $error("divider finished without done");

endmodule

>>> hw/rtl/apc_datapath.sv
module apc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apc_pkg::ctl_cmd_t             ctl_i,
  output apc_pkg::ctl_status_t          status_o,
  input  logic [apc_pkg::FpsW-1:0]      fps_i,
  input  logic [apc_pkg::TimeW-1:0]     blend_time_i,
  input  logic [apc_pkg::FuncW-1:0]     func_i,
  input  logic [apc_pkg::TimeW-1:0]     delta_time_i,
  input  logic [apc_pkg::FrameW-1:0]    move_frames_i,
  input  logic                          move_loops_i,
  input  logic [apc_pkg::FrameW-1:0]    target_frame_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [apc_pkg::FrameW-1:0]    current_frame_o,
  output logic                          is_playing_o,
  output logic [apc_pkg::LoopW-1:0]     loops_done_o,
  output logic                          blend_active_o,
  output logic [apc_pkg::WeightW-1:0]   blend_weight_o,
  output logic [apc_pkg::TimeW-1:0]     play_time_o
);

  localparam int unsigned TimeW  = apc_pkg::TimeW;
  localparam int unsigned FrameW = apc_pkg::FrameW;
  localparam int unsigned FpsW   = apc_pkg::FpsW;
  localparam int unsigned ProdW  = TimeW + FpsW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned ScaleW = ProdW - FracW;

  // Where a finished division goes.
  typedef enum logic [1:0] {
    DEST_DURATION,
    DEST_ELAPSED,
    DEST_MOD,
    DEST_BLEND
  } dest_e;

  // Latched command fields.
  logic [apc_pkg::FuncW-1:0] func_q;
  logic [TimeW-1:0]          delta_q;
  logic [FrameW-1:0]         frames_q;
  logic                      loops_q;
  logic [FrameW-1:0]         target_q;

  // Playback state.
  logic [TimeW-1:0]          elapsed_q;
  logic [TimeW-1:0]          duration_q;
  logic [FrameW-1:0]         total_q;
  logic                      repeat_q;
  logic                      running_q;
  logic [apc_pkg::LoopW-1:0] wrap_q;
  logic                      loaded_q;
  logic                      prior_q;

  // Result staging.
  dest_e                       dest_q;
  logic                        blend_q;
  logic [apc_pkg::WeightW-1:0] weight_q;
  logic [ScaleW-1:0]           scaled_q;

  // Output register.
  logic                        out_valid_q;
  logic [FrameW-1:0]           out_frame_q;
  logic                        out_playing_q;
  logic [apc_pkg::LoopW-1:0]   out_loops_q;
  logic                        out_blend_q;
  logic [apc_pkg::WeightW-1:0] out_weight_q;
  logic [TimeW-1:0]            out_time_q;

  logic [FpsW-1:0]           fps_eff;
  logic [TimeW:0]            sum;
  logic [TimeW-1:0]          sat;
  logic                      overrun;
  logic                      need_div;
  logic                      blending;
  logic                      div_start;
  logic [TimeW-1:0]          div_rem_init, div_dividend, div_divisor;
  logic [apc_pkg::DivCntW-1:0] div_steps;
  dest_e                     div_dest;
  logic                      div_done;
  logic [TimeW-1:0]          div_quo, div_rem;
  logic [ProdW-1:0]          prod;
  logic [FrameW-1:0]         frame_clamped;

  // A frame rate of zero counts as one.
  assign fps_eff = (fps_i == '0) ? FpsW'(1) : fps_i;

  // Saturating tick add and the overrun check against the duration.
  assign sum     = {1'b0, elapsed_q} + {1'b0, delta_q};
  assign sat     = sum[TimeW] ? '1 : sum[TimeW-1:0];
  assign overrun = running_q && (func_q == apc_pkg::FUNC_TICK) && (sat > duration_q);

  // Commands that need the shared divider.
  always_comb begin
    need_div = 1'b0;
    unique case (func_q)
      apc_pkg::FUNC_TICK:  need_div = overrun && repeat_q && (duration_q != '0);
      apc_pkg::FUNC_START: need_div = 1'b1;
      apc_pkg::FUNC_GOTO:  need_div = loaded_q;
      default:             need_div = 1'b0;
    endcase
  end

  assign blending = prior_q && loaded_q && (elapsed_q < blend_time_i) && (wrap_q == '0);

  // Divider operand selection.
  always_comb begin
    div_rem_init = '0;
    div_dividend = {frames_q, {FracW{1'b0}}};
    div_divisor  = TimeW'(fps_eff);
    div_steps    = apc_pkg::DivCntW'(TimeW);
    div_dest     = DEST_DURATION;
    if (ctl_i.post) begin
      // Remainder starts at the elapsed time; sixteen fraction bits follow.
      div_rem_init = elapsed_q;
      div_dividend = '0;
      div_divisor  = blend_time_i;
      div_steps    = apc_pkg::DivCntW'(apc_pkg::WeightW);
      div_dest     = DEST_BLEND;
    end else if (func_q == apc_pkg::FUNC_GOTO) begin
      div_dividend = {target_q, {FracW{1'b0}}};
      div_dest     = DEST_ELAPSED;
    end else if (func_q == apc_pkg::FUNC_TICK) begin
      div_dividend = sat;
      div_divisor  = duration_q;
      div_dest     = DEST_MOD;
    end
  end

  assign div_start = (ctl_i.exec && need_div) || (ctl_i.post && blending);

  apc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Latch the command fields when a transaction is accepted.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      func_q   <= func_i;
      delta_q  <= delta_time_i;
      frames_q <= move_frames_i;
      loops_q  <= move_loops_i;
      target_q <= target_frame_i;
    end
  end

  // Playback state: command execution and division results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      duration_q <= '0;
      total_q    <= '0;
      repeat_q   <= 1'b1;
      running_q  <= 1'b0;
      wrap_q     <= '0;
      loaded_q   <= 1'b0;
      prior_q    <= 1'b0;
    end else if (ctl_i.exec) begin
      unique case (func_q)
        apc_pkg::FUNC_TICK: begin
          if (running_q) begin
            if (!overrun) begin
              elapsed_q <= sat;
            end else if (repeat_q) begin
              // A zero-length looping move wraps straight to zero.
              elapsed_q <= '0;
              if (wrap_q != '1) begin
                wrap_q <= wrap_q + 1'b1;
              end
            end else begin
              elapsed_q <= duration_q;
            end
          end
        end
        apc_pkg::FUNC_START: begin
          prior_q   <= loaded_q;
          loaded_q  <= 1'b1;
          repeat_q  <= loops_q;
          total_q   <= frames_q;
          elapsed_q <= '0;
          running_q <= 1'b1;
          wrap_q    <= '0;
        end
        apc_pkg::FUNC_GOTO: begin
          if (loaded_q) begin
            running_q <= 1'b0;
          end
        end
        apc_pkg::FUNC_PAUSE: running_q <= 1'b0;
        apc_pkg::FUNC_RESUME: begin
          if (loaded_q) begin
            running_q <= 1'b1;
          end
        end
        apc_pkg::FUNC_STOP: begin
          elapsed_q <= '0;
          running_q <= 1'b0;
        end
        default: ;
      endcase
    end else if (ctl_i.div_commit) begin
      case (dest_q)
        DEST_DURATION: duration_q <= div_quo;
        DEST_ELAPSED:  elapsed_q  <= div_quo;
        DEST_MOD:      elapsed_q  <= div_rem;
        default: ;
      endcase
    end
  end

  // Result staging: divider target, blend weight and scaled frame.
  assign prod = ProdW'(fps_eff) * ProdW'(elapsed_q);

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      dest_q <= div_dest;
    end
    if (ctl_i.post) begin
      blend_q  <= blending;
      weight_q <= '0;
    end else if (ctl_i.div_commit && dest_q == DEST_BLEND) begin
      weight_q <= div_quo[apc_pkg::WeightW-1:0];
    end
    if (ctl_i.mul) begin
      scaled_q <= prod[ProdW-1:FracW];
    end
  end

  // Frame clamp to the last frame of the move.
  always_comb begin
    if (total_q == '0) begin
      frame_clamped = '0;
    end else if (scaled_q >= ScaleW'(total_q)) begin
      frame_clamped = total_q - 1'b1;
    end else begin
      frame_clamped = scaled_q[FrameW-1:0];
    end
  end

  // Output register; it is refilled once the previous transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_frame_q   <= frame_clamped;
      out_playing_q <= running_q;
      out_loops_q   <= wrap_q;
      out_blend_q   <= blend_q;
      out_weight_q  <= weight_q;
      out_time_q    <= elapsed_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.need_div = need_div;
  assign status_o.blending = blending;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign current_frame_o = out_frame_q;
  assign is_playing_o    = out_playing_q;
  assign loops_done_o    = out_loops_q;
  assign blend_active_o  = out_blend_q;
  assign blend_weight_o  = out_weight_q;
  assign play_time_o     = out_time_q;

  // A previous move can only be recorded once a move has been loaded.
  a_prior_needs_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !loaded_q |-> !prior_q)
    else $error("prior move set without a loaded move");

  // The weight is zero in every result that is not blending.
  a_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_blend_q) |-> (out_weight_q == '0))
    else $error("blend weight set outside the blend window");

  // Loading the output register always presents a result.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |=> out_valid_q)
    else $error("result lost after emit");

endmodule

>>> hw/rtl/apc_ctrl.sv
module apc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  apc_pkg::ctl_status_t  status_i,
  output apc_pkg::ctl_cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_POST = 7'b0001000,
    S_BDIV = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Sequencing of one command: load, execute, optional division, optional blend, scale, emit.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.need_div ? S_DIV : S_POST;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.div_commit = 1'b1;
          state_d          = S_POST;
        end
      end
      S_POST: begin
        cmd_o.post = 1'b1;
        state_d    = status_i.blending ? S_BDIV : S_MUL;
      end
      S_BDIV: begin
        if (status_i.div_done) begin
          cmd_o.div_commit = 1'b1;
          state_d          = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/animation_playback_clock_unit.sv
// Animation playback clock: one command transaction in, one result transaction out.
// Commands are taken one at a time. An accepted command passes EXEC, POST, MUL and EMIT,
// which loads the output register and returns to IDLE for the next command. A command
// that needs a division (start move, go to frame, or a tick that wraps a looping move)
// also waits in DIV, and one that computes the blend weight in BDIV, both on the single
// shared bit-serial divider, which resolves one quotient bit per cycle. The result sits in
// an output register, so the next command is accepted while it waits to be taken.
// Registers: frames per second at byte address 0 (8 bits, zero acts as one) and the blend
// window at byte address 4 (Q16.16 seconds).
module animation_playback_clock_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  apc_cmd_if.sink                   cmd_i,
  apc_res_if.source                 res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [apc_pkg::FpsW-1:0]  fps_q;
  logic [apc_pkg::TimeW-1:0] blend_q;
  logic                      cfg_write;
  apc_pkg::reg_e             reg_sel;

  apc_pkg::ctl_cmd_t         ctl_cmd;
  apc_pkg::ctl_status_t      ctl_status;

  // Configuration registers on the APB-style port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = apc_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q   <= apc_pkg::FpsReset;
      blend_q <= apc_pkg::BlendReset;
    end else if (cfg_write) begin
      unique case (reg_sel)
        apc_pkg::REG_FPS:   fps_q   <= pwdata[apc_pkg::FpsW-1:0];
        apc_pkg::REG_BLEND: blend_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      apc_pkg::REG_FPS:   prdata = 32'(fps_q);
      apc_pkg::REG_BLEND: prdata = blend_q;
      default:            prdata = '0;
    endcase
  end

  // Controller and datapath.
  apc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .status_i   (ctl_status),
    .cmd_o      (ctl_cmd)
  );

  apc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl_cmd),
    .status_o        (ctl_status),
    .fps_i           (fps_q),
    .blend_time_i    (blend_q),
    .func_i          (cmd_i.func),
    .delta_time_i    (cmd_i.delta_time),
    .move_frames_i   (cmd_i.move_frames),
    .move_loops_i    (cmd_i.move_loops),
    .target_frame_i  (cmd_i.target_frame),
    .out_valid_o     (res_o.valid),
    .out_ready_i     (res_o.ready),
    .current_frame_o (res_o.current_frame),
    .is_playing_o    (res_o.is_playing),
    .loops_done_o    (res_o.loops_done),
    .blend_active_o  (res_o.blend_active),
    .blend_weight_o  (res_o.blend_weight),
    .play_time_o     (res_o.play_time)
  );

endmodule
